// ===== rtl/core/bprd_pkg.sv =====
// Shared types, codes and calendar helpers for the blood-pressure record decoder.
package bprd_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 9;

    localparam logic [CfgIndexWidth-1:0] CFG_SYSTOLIC_MIN   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SYSTOLIC_MAX   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_DIASTOLIC_MIN  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_DIASTOLIC_MAX  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_PULSE_MIN      = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_PULSE_MAX      = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_YEAR_LIMIT     = 3'd6;
    localparam logic [CfgIndexWidth-1:0] CFG_CLOCK_SET_YEAR = 3'd7;

    localparam logic [8:0] SYSTOLIC_MIN_RST   = 9'd60;
    localparam logic [8:0] SYSTOLIC_MAX_RST   = 9'd260;
    localparam logic [7:0] DIASTOLIC_MIN_RST  = 8'd30;
    localparam logic [7:0] DIASTOLIC_MAX_RST  = 8'd200;
    localparam logic [7:0] PULSE_MIN_RST      = 8'd30;
    localparam logic [7:0] PULSE_MAX_RST      = 8'd220;
    localparam logic [7:0] YEAR_LIMIT_RST     = 8'd100;
    localparam logic [7:0] CLOCK_SET_YEAR_RST = 8'd16;

    localparam logic [8:0]  SYSTOLIC_BIAS = 9'd25;
    localparam logic [11:0] YEAR_BASE     = 12'd2000;
    localparam logic [5:0]  SECOND_MAX    = 6'd59;
    localparam logic [5:0]  MINUTE_LIMIT  = 6'd60;
    localparam logic [4:0]  HOUR_LIMIT    = 5'd24;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    // Century years in range that are not leap years: 2100 and 2200.
    localparam logic [7:0]  CENTURY_A_OFF = 8'd100;
    localparam logic [7:0]  CENTURY_B_OFF = 8'd200;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_IMPLAUS   = 2'd2,
        STATUS_BAD_DATE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] record_front;
        logic [47:0] record_back;
    } record_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  systolic;
        logic [7:0]  diastolic;
        logic [7:0]  pulse;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  flags;
        logic [7:0]  arrhythmia_count;
    } result_t;

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        begin
            case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
                MONTH_FEB:                                  days = leap ? 5'd29 : 5'd28;
                default:                                    days = 5'd0;
            endcase
            return days;
        end
    endfunction

endpackage

// ===== rtl/core/bp_record_decoder.sv =====
// Top level of the blood-pressure record decoder: three-stage request pipeline.
// Takes one 14-byte record per cycle while record_stall is low and returns one decoded
// result per record, in order. A request passes from the stage 1 register to stage 2 and
// then to the stage 3 output register; the result stays on the output until the result
// side does not stall. Stage 1 registers the record, stage 2 holds the unpacked fields
// and the threshold and calendar compares, stage 3 is the output register with the final
// status. Each stage advances when it is empty or the stage after it moves, so new
// requests are taken while a result waits. Thresholds are written through the cfg port,
// which is always ready; write them only while no record is in flight.
module bp_record_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 record_valid,
    output logic                                 record_stall,
    input  bprd_pkg::record_t                    record,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output bprd_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bprd_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [bprd_pkg::CfgDataWidth-1:0]    cfg_data
);

    typedef struct packed {
        logic             empty;
        logic             bp_ok;
        logic             time_ok;
        logic [4:0]       mdays;
        bprd_pkg::result_t fields;
    } s2_t;

    logic [8:0] sys_min_reg, sys_max_reg;
    logic [7:0] dia_min_reg, dia_max_reg, pul_min_reg, pul_max_reg;
    logic [7:0] year_limit_reg, clock_year_reg;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    bprd_pkg::record_t s1_rec_reg;
    s2_t               s2_reg, s2_next;
    bprd_pkg::result_t s3_reg, s3_next;
    logic              s1_ready, s2_ready, s3_ready;

    logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7, b8;
    logic [8:0] sys;
    logic [5:0] sec_raw;
    logic       leap;
    logic       date_ok;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_min_reg    <= bprd_pkg::SYSTOLIC_MIN_RST;
            sys_max_reg    <= bprd_pkg::SYSTOLIC_MAX_RST;
            dia_min_reg    <= bprd_pkg::DIASTOLIC_MIN_RST;
            dia_max_reg    <= bprd_pkg::DIASTOLIC_MAX_RST;
            pul_min_reg    <= bprd_pkg::PULSE_MIN_RST;
            pul_max_reg    <= bprd_pkg::PULSE_MAX_RST;
            year_limit_reg <= bprd_pkg::YEAR_LIMIT_RST;
            clock_year_reg <= bprd_pkg::CLOCK_SET_YEAR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bprd_pkg::CFG_SYSTOLIC_MIN:   sys_min_reg    <= cfg_data;
                bprd_pkg::CFG_SYSTOLIC_MAX:   sys_max_reg    <= cfg_data;
                bprd_pkg::CFG_DIASTOLIC_MIN:  dia_min_reg    <= cfg_data[7:0];
                bprd_pkg::CFG_DIASTOLIC_MAX:  dia_max_reg    <= cfg_data[7:0];
                bprd_pkg::CFG_PULSE_MIN:      pul_min_reg    <= cfg_data[7:0];
                bprd_pkg::CFG_PULSE_MAX:      pul_max_reg    <= cfg_data[7:0];
                bprd_pkg::CFG_YEAR_LIMIT:     year_limit_reg <= cfg_data[7:0];
                bprd_pkg::CFG_CLOCK_SET_YEAR: clock_year_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign s3_ready     = !s3_valid_reg || !result_stall;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign record_stall = !s1_ready;
    assign result_valid = s3_valid_reg;
    assign result       = s3_reg;

    // stage 2: unpack and compare
    always_comb
    begin
        b0 = s1_rec_reg.record_front[63:56];
        b1 = s1_rec_reg.record_front[55:48];
        b2 = s1_rec_reg.record_front[47:40];
        b3 = s1_rec_reg.record_front[39:32];
        b4 = s1_rec_reg.record_front[31:24];
        b5 = s1_rec_reg.record_front[23:16];
        b6 = s1_rec_reg.record_front[15:8];
        b7 = s1_rec_reg.record_front[7:0];
        b8 = s1_rec_reg.record_back[47:40];

        sys     = {1'b0, b1} + bprd_pkg::SYSTOLIC_BIAS;
        sec_raw = b7[5:0];
        leap    = (b2[1:0] == 2'b00) && (b2 != bprd_pkg::CENTURY_A_OFF)
                  && (b2 != bprd_pkg::CENTURY_B_OFF);

        s2_next.empty = (&s1_rec_reg.record_front) && (&s1_rec_reg.record_back);

        s2_next.bp_ok = (sys >= sys_min_reg) && (sys <= sys_max_reg)
                        && (b0 >= dia_min_reg) && (b0 <= dia_max_reg)
                        && (sys > {1'b0, b0})
                        && (b3 >= pul_min_reg) && (b3 <= pul_max_reg);

        s2_next.time_ok = ({b5[4:0]} < bprd_pkg::HOUR_LIMIT)
                          && ({b6[3:0], b7[7:6]} < bprd_pkg::MINUTE_LIMIT)
                          && (b2 <= year_limit_reg);

        s2_next.mdays = bprd_pkg::month_days(b4[5:2], leap);

        s2_next.fields.status           = bprd_pkg::STATUS_OK;
        s2_next.fields.systolic         = sys;
        s2_next.fields.diastolic        = b0;
        s2_next.fields.pulse            = b3;
        s2_next.fields.year             = {4'd0, b2} + bprd_pkg::YEAR_BASE;
        s2_next.fields.month            = b4[5:2];
        s2_next.fields.day              = {b4[1:0], b5[7:5]};
        s2_next.fields.hour             = b5[4:0];
        s2_next.fields.minute           = {b6[3:0], b7[7:6]};
        s2_next.fields.second           = (sec_raw > bprd_pkg::SECOND_MAX)
                                          ? bprd_pkg::SECOND_MAX : sec_raw;
        s2_next.fields.flags            = {(b2 >= clock_year_reg), b4[6], b4[7]};
        s2_next.fields.arrhythmia_count = b8;
    end

    // stage 3: day check and status
    always_comb
    begin
        date_ok = (s2_reg.fields.day != 5'd0) && (s2_reg.fields.day <= s2_reg.mdays)
                  && s2_reg.time_ok;
        s3_next = s2_reg.fields;
        if (s2_reg.empty)
        begin
            s3_next        = '0;
            s3_next.status = bprd_pkg::STATUS_EMPTY;
        end
        else if (!s2_reg.bp_ok)
        begin
            s3_next.status = bprd_pkg::STATUS_IMPLAUS;
        end
        else if (!date_ok)
        begin
            s3_next.status = bprd_pkg::STATUS_BAD_DATE;
        end
        else
        begin
            s3_next.status = bprd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= record_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && record_valid)
        begin
            s1_rec_reg <= record;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule
